### hdl/scfc_pkg.sv
package scfc_pkg;

    localparam int FIFO_DEPTH = 71;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int POS_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CNT_W      = 7;
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [7:0] REG_SPEED_LO = 8'h22;
    localparam logic [7:0] REG_SPEED_HI = 8'h23;
    localparam logic [7:0] REG_CNTRL_HI = 8'h03;
    localparam logic [7:0] REG_OPCODE   = 8'h45;
    localparam logic [7:0] REG_TRIGGER  = 8'h47;
    localparam logic [7:0] REG_TXCNT    = 8'h48;
    localparam logic [7:0] REG_RXCNT    = 8'h4b;
    localparam logic [7:0] REG_STATUS   = 8'h4f;
    localparam logic [7:0] REG_FIFO     = 8'h80;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SLOT  = 2'd2
    } cmd_t;

    // result fields held between the state update and the FIFO read data
    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] mosi_byte;
        logic       rdata_from_fifo;
        logic       mosi_from_fifo;
        logic       mosi_valid;
        logic       chip_select;
        logic       busy_flag;
        logic       length_error;
    } stage_res_t;

endpackage

### hdl/spi_command_fifo_controller.sv
// An s_ transfer passes to its m_ result through the input register, the state
// update with FIFO access and the result register. One item per cycle while
// m_tready does not stall; the FIFO memory has one read and one write port.
// Reset (aresetn low, synchronous): registers, counts, busy and position clear,
// pipeline empties; FIFO contents stay undefined until written.
module spi_command_fifo_controller
    import scfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // addr[7:0], wdata[15:8], miso_byte[23:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // rdata[7:0], mosi_byte[15:8], mosi_valid[16],
                                   // chip_select[17], busy_flag[18], length_error[19]
);

    // pipeline control
    logic v1_reg, v2_reg, out_valid_reg;
    logic adv1, adv2, in_xfer;

    // input register
    cmd_t       cmd_reg;
    logic [7:0] addr_reg, wdata_reg, miso_reg;

    // block state
    logic [7:0]       opcode_reg, opcode_next;
    logic [CNT_W-1:0] tx_reg, tx_next;
    logic [CNT_W-1:0] rx_reg, rx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             busy_reg, busy_next;
    logic [15:0]      speed_reg, speed_next;

    // FIFO memory
    logic [7:0]       fifo_mem [FIFO_DEPTH];
    logic [7:0]       rd_reg;
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] waddr, raddr;

    stage_res_t res, s2_reg;

    logic [7:0] out_rdata_reg, out_mosi_reg;
    logic       out_mv_reg, out_cs_reg, out_busy_reg, out_lerr_reg;

    logic             fifo_hit;
    logic [6:0]       addr_off;
    logic [IDX_W-1:0] fifo_idx, slot_idx;
    logic [POS_W-1:0] pos_m1;
    logic [SUM_W-1:0] len_sum, total, pos_inc;

    assign adv2     = v2_reg && (!out_valid_reg || m_tready);
    assign adv1     = v1_reg && (!v2_reg || adv2);
    assign s_tready = !v1_reg || adv1;
    assign in_xfer  = s_tvalid && s_tready;

    assign addr_off = addr_reg[6:0];
    assign fifo_hit = addr_reg[7] && ({1'b0, addr_off} < 8'(FIFO_DEPTH));
    assign fifo_idx = addr_off[IDX_W-1:0];
    assign pos_m1   = pos_reg - POS_W'(1);
    assign slot_idx = pos_m1[IDX_W-1:0];
    assign len_sum  = SUM_W'(tx_reg) + SUM_W'(rx_reg);
    assign total    = len_sum + SUM_W'(1);
    assign pos_inc  = SUM_W'(pos_reg) + SUM_W'(1);

    always_comb begin
        opcode_next = opcode_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        pos_next    = pos_reg;
        busy_next   = busy_reg;
        speed_next  = speed_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        waddr       = fifo_idx;
        raddr       = fifo_idx;
        res         = '0;
        case (cmd_reg)
            CMD_WRITE: begin
                if (addr_reg == REG_SPEED_LO) begin
                    speed_next[7:0] = wdata_reg;
                end else if (addr_reg == REG_SPEED_HI) begin
                    speed_next[15:8] = wdata_reg;
                end else if (!busy_reg) begin
                    if (fifo_hit) begin
                        mem_we = 1'b1;
                    end else begin
                        case (addr_reg)
                            REG_OPCODE: opcode_next = wdata_reg;
                            REG_TXCNT:  tx_next = wdata_reg[CNT_W-1:0];
                            REG_RXCNT:  rx_next = wdata_reg[CNT_W-1:0];
                            REG_TRIGGER: begin
                                if (wdata_reg[7]) begin
                                    if (len_sum > SUM_W'(FIFO_DEPTH)) begin
                                        res.length_error = 1'b1;
                                    end else begin
                                        busy_next = 1'b1;
                                        pos_next  = '0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_READ: begin
                if (fifo_hit) begin
                    mem_re              = 1'b1;
                    res.rdata_from_fifo = 1'b1;
                end else begin
                    case (addr_reg)
                        REG_OPCODE:   res.rdata = opcode_reg;
                        REG_TXCNT:    res.rdata = 8'(tx_reg);
                        REG_RXCNT:    res.rdata = 8'(rx_reg);
                        REG_TRIGGER,
                        REG_STATUS,
                        REG_CNTRL_HI: res.rdata = {busy_reg, 7'd0};
                        REG_SPEED_LO: res.rdata = speed_reg[7:0];
                        REG_SPEED_HI: res.rdata = speed_reg[15:8];
                        default:      res.rdata = 8'd0;
                    endcase
                end
            end
            CMD_SLOT: begin
                if (busy_reg) begin
                    res.mosi_valid = 1'b1;
                    if (pos_reg == '0) begin
                        res.mosi_byte = opcode_reg;
                    end else if (SUM_W'(pos_m1) < SUM_W'(FIFO_DEPTH)) begin
                        if (SUM_W'(pos_reg) <= SUM_W'(tx_reg)) begin
                            mem_re             = 1'b1;
                            raddr              = slot_idx;
                            res.mosi_from_fifo = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            waddr  = slot_idx;
                        end
                    end
                    if (pos_inc >= total) begin
                        busy_next = 1'b0;
                        pos_next  = '0;
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        res.busy_flag   = busy_next;
        res.chip_select = res.mosi_valid | busy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            opcode_reg    <= '0;
            tx_reg        <= '0;
            rx_reg        <= '0;
            pos_reg       <= '0;
            busy_reg      <= 1'b0;
            speed_reg     <= '0;
        end else begin
            if (s_tready) begin
                v1_reg <= s_tvalid;
            end
            if (!v2_reg || adv2) begin
                v2_reg <= adv1;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= adv2;
            end
            if (adv1) begin
                opcode_reg <= opcode_next;
                tx_reg     <= tx_next;
                rx_reg     <= rx_next;
                pos_reg    <= pos_next;
                busy_reg   <= busy_next;
                speed_reg  <= speed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg   <= cmd_t'(s_tuser);
            addr_reg  <= s_tdata[7:0];
            wdata_reg <= s_tdata[15:8];
            miso_reg  <= s_tdata[23:16];
        end
        if (adv1) begin
            s2_reg <= res;
        end
        if (adv2) begin
            out_rdata_reg <= s2_reg.rdata_from_fifo ? rd_reg : s2_reg.rdata;
            out_mosi_reg  <= s2_reg.mosi_from_fifo ? rd_reg : s2_reg.mosi_byte;
            out_mv_reg    <= s2_reg.mosi_valid;
            out_cs_reg    <= s2_reg.chip_select;
            out_busy_reg  <= s2_reg.busy_flag;
            out_lerr_reg  <= s2_reg.length_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && mem_we) begin
            fifo_mem[waddr] <= (cmd_reg == CMD_SLOT) ? miso_reg : wdata_reg;
        end
        if (adv1 && mem_re) begin
            rd_reg <= fifo_mem[raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_lerr_reg, out_busy_reg, out_cs_reg, out_mv_reg,
                       out_mosi_reg, out_rdata_reg};

    a_idle_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pos_reg == '0)
        else $error("position nonzero while idle");

    a_busy_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> len_sum <= SUM_W'(FIFO_DEPTH))
        else $error("busy with tx plus rx over depth");

    a_mosi_has_cs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tdata[17])
        else $error("transfer byte without chip select");

    a_lerr_not_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> !m_tdata[16] && !m_tdata[18])
        else $error("length error together with a transfer or busy");

    a_mem_single_op: assert property (@(posedge aclk) disable iff (!aresetn)
        adv1 |-> !(mem_we && mem_re))
        else $error("FIFO read and write from one item");

endmodule
